@@ rtl/core/l2s_pkg.sv @@
// Package: shared constants and elaboration-time threshold functions for the sRGB encoder.
package l2s_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned ChanW  = 32;
  localparam int unsigned MagW   = 31;
  localparam int unsigned NCodes = 256;
  localparam logic [MagW-1:0] OneBits = 31'h3F80_0000;

  function automatic logic power_reaches(input logic [63:0] m, input int unsigned s,
                                         input int unsigned k);
    logic [383:0] lhs;
    logic [383:0] rhs;
    lhs = 384'(m);
    for (int i = 0; i < 4; i++) lhs = lhs * 384'(m);
    for (int i = 0; i < 12; i++) lhs = lhs * 384'(10761);
    rhs = 384'(1);
    for (int i = 0; i < 12; i++) rhs = rhs * 384'(40 * k + 541);
    rhs = rhs << (5 * s);
    return lhs >= rhs;
  endfunction

  function automatic int unsigned ref_code(input logic [MagW-1:0] b, input logic raw);
    int unsigned e;
    logic [63:0] m;
    int unsigned s;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic lin;
    logic [63:0] num;
    logic [63:0] den;
    int unsigned q;
    e = int'(b[30:23]);
    if (e >= 127) return 255;
    if (e < 100) return 0;
    m = {40'd0, 1'b1, b[22:0]};
    s = 150 - e;
    if (raw) return int'(((m * 64'd510 + (64'd1 << s)) >> (s + 1)) & 64'hFF);
    lin = 1'b1;
    if (e >= 118) lin = (m * 64'd10000000) <= (64'd31308 << s);
    if (lin) begin
      // linear segment never exceeds a dozen codes, so subtract repeatedly
      num = m * 64'd32946 + (64'd5 << s);
      den = 64'd10 << s;
      q = 0;
      while (num >= den) begin
        num = num - den;
        q++;
      end
      return q;
    end
    lo = 10;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (power_reaches(m, s, mid)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // smallest magnitude pattern whose code reaches k
  function automatic logic [MagW-1:0] threshold(input logic raw, input int unsigned k);
    logic [MagW-1:0] lo;
    logic [MagW-1:0] hi;
    logic [MagW-1:0] mid;
    lo = '0;
    hi = OneBits;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (ref_code(mid, raw) >= k) hi = mid;
      else lo = mid + 1'b1;
    end
    return lo;
  endfunction

endpackage

@@ rtl/core/l2s_channel.sv @@
// One channel: maps a float bit pattern to its 8-bit code by threshold search.
module l2s_channel import l2s_pkg::*; (
  input  logic [ChanW-1:0] bits,
  input  logic             raw,
  output logic [CodeW-1:0] code
);

  logic [MagW-1:0] thr_lin [NCodes];
  logic [MagW-1:0] thr_raw [NCodes];

  assign thr_lin[0] = '0;
  assign thr_raw[0] = '0;

  for (genvar k = 1; k < NCodes; k++) begin : g_thr
    localparam logic [MagW-1:0] TLin = threshold(1'b0, k);
    localparam logic [MagW-1:0] TRaw = threshold(1'b1, k);
    assign thr_lin[k] = TLin;
    assign thr_raw[k] = TRaw;
  end

  logic            is_nan;
  logic [CodeW-1:0] lo;
  logic [CodeW-1:0] cand;
  logic [MagW-1:0]  t;

  always_comb begin
    is_nan = (bits[30:23] == 8'hFF) && (bits[22:0] != '0);
    lo = '0;
    for (int i = CodeW - 1; i >= 0; i--) begin
      cand = lo | (CodeW'(1) << i);
      t = raw ? thr_raw[cand] : thr_lin[cand];
      if (bits[MagW-1:0] >= t) lo = cand;
    end
    code = (bits[ChanW-1] || is_nan) ? '0 : lo;
  end

endmodule

@@ rtl/core/linear_to_srgb8_pixel_encoder.sv @@
// Top level: linear float RGB pixel to 8-bit sRGB codes, two register stages.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | red_bits, green_bits, blue_bits
// out     | output    | out_valid / out_stall| red_code, green_code, blue_code
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (raw_passthrough)
//
// One pixel per cycle while out_stall is low; a pixel passes the input register, then the result register.
// The threshold search sits between the two registers and sets the logic depth only.
// Reset (rst, synchronous) empties both stages and clears raw_passthrough.
// A stalled output holds; the input stalls only when both stages are full.
module linear_to_srgb8_pixel_encoder import l2s_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ChanW-1:0] red_bits,
  input  logic [ChanW-1:0] green_bits,
  input  logic [ChanW-1:0] blue_bits,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CodeW-1:0] red_code,
  output logic [CodeW-1:0] green_code,
  output logic [CodeW-1:0] blue_code,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  logic             raw;
  logic             s1_valid;
  logic [ChanW-1:0] s1_red, s1_green, s1_blue;
  logic [CodeW-1:0] red_next, green_next, blue_next;
  logic             en2, en1;

  assign cfg_ready = 1'b1;
  assign en2 = !out_valid || !out_stall;
  assign en1 = !s1_valid || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) raw <= 1'b0;
    else if (cfg_valid) raw <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_red   <= red_bits;
      s1_green <= green_bits;
      s1_blue  <= blue_bits;
    end
    if (en2 && s1_valid) begin
      red_code   <= red_next;
      green_code <= green_next;
      blue_code  <= blue_next;
    end
  end

  l2s_channel u_red   (.bits(s1_red),   .raw(raw), .code(red_next));
  l2s_channel u_green (.bits(s1_green), .raw(raw), .code(green_next));
  l2s_channel u_blue  (.bits(s1_blue),  .raw(raw), .code(blue_next));

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with a free stage");

  a_sign_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && en2 && s1_red[ChanW-1]) |=> (red_code == '0))
    else $error("negative red not coded as zero");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> (raw == $past(cfg_data)))
    else $error("configuration write lost");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && en2) |=> out_valid)
    else $error("transaction dropped between stages");

endmodule

@@ verif/linear_to_srgb8_pixel_checker.sv @@
`timescale 1ns / 100ps
// Checker: watches the encoder channels, predicts each pixel's codes and compares them.
module linear_to_srgb8_pixel_checker import l2s_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ChanW-1:0] red_bits,
  input  logic [ChanW-1:0] green_bits,
  input  logic [ChanW-1:0] blue_bits,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CodeW-1:0] red_code,
  input  logic [CodeW-1:0] green_code,
  input  logic [CodeW-1:0] blue_code,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_data,
  output int               fail_count,
  output int               codes_pending
);

  typedef struct packed {
    logic [CodeW-1:0] red;
    logic [CodeW-1:0] green;
    logic [CodeW-1:0] blue;
  } pixel_codes_t;

  pixel_codes_t expected_codes[$];
  logic         raw_mode;

  // curve reaches code k when m^5 * 10761^12 >= (40k+541)^12 * 2^(5s)
  function automatic logic curve_reaches(input logic [63:0] m, input int unsigned s,
                                         input int unsigned k);
    logic [447:0] lhs;
    logic [447:0] rhs;
    lhs = 448'(m);
    for (int i = 0; i < 4; i++) lhs = lhs * 448'(m);
    for (int i = 0; i < 12; i++) lhs = lhs * 448'd10761;
    rhs = 448'd1;
    for (int i = 0; i < 12; i++) rhs = rhs * 448'(40 * k + 541);
    rhs = rhs << (5 * s);
    return lhs >= rhs;
  endfunction

  function automatic logic [CodeW-1:0] srgb_code(input logic [31:0] bits, input logic raw);
    int unsigned expo;
    logic [63:0] m;
    int unsigned s;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [63:0] q;
    expo = 32'(bits[30:23]);
    if (bits[31]) return 8'd0;
    if (expo == 255) return (bits[22:0] != 0) ? 8'd0 : 8'd255;
    if (expo >= 127) return 8'd255;
    if (expo < 100) return 8'd0;
    m = {40'd0, 1'b1, bits[22:0]};
    s = 150 - expo;
    if (raw) begin
      q = (m * 64'd510 + (64'd1 << s)) >> (s + 1);
      return q[7:0];
    end
    if (expo < 118 || (m * 64'd10000000) <= (64'd31308 << s)) begin
      q = (m * 64'd32946 + (64'd5 << s)) / (64'd10 << s);
      return q[7:0];
    end
    lo = 10;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (curve_reaches(m, s, mid)) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

  always @(posedge clk) begin
    pixel_codes_t pred;
    pixel_codes_t exp_px;
    if (rst) begin
      raw_mode      <= 1'b0;
      fail_count    <= 0;
      codes_pending <= 0;
      expected_codes.delete();
    end else begin
      if (cfg_valid && cfg_ready) raw_mode <= cfg_data;
      if (in_valid && !in_stall) begin
        pred.red   = srgb_code(red_bits, raw_mode);
        pred.green = srgb_code(green_bits, raw_mode);
        pred.blue  = srgb_code(blue_bits, raw_mode);
        expected_codes = {expected_codes, pred};
      end
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction: %h %h %h",
                                        red_code, green_code, blue_code);
          fail_count <= fail_count + 1;
        end else begin
          exp_px = expected_codes.pop_front();
          if (exp_px.red !== red_code || exp_px.green !== green_code ||
              exp_px.blue !== blue_code) begin
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h, got %h %h %h", exp_px.red,
                       exp_px.green, exp_px.blue, red_code, green_code, blue_code);
            fail_count <= fail_count + 1;
          end
        end
      end
      codes_pending <= expected_codes.size();
    end
  end

endmodule

@@ verif/tb_linear_to_srgb8_pixel_encoder.sv @@
`timescale 1ns / 100ps
// Testbench top: drives pixels and raw/curve settings into the encoder and reports the verdict.
module tb_linear_to_srgb8_pixel_encoder import l2s_pkg::*; ();

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ChanW-1:0] red_bits = '0;
  logic [ChanW-1:0] green_bits = '0;
  logic [ChanW-1:0] blue_bits = '0;
  logic             out_valid;
  logic             out_stall = 1'b1;
  logic [CodeW-1:0] red_code;
  logic [CodeW-1:0] green_code;
  logic [CodeW-1:0] blue_code;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data = 1'b0;
  int               fail_count;
  int               codes_pending;
  int               cycle_count = 0;

  localparam int CycleLimit = 400000;

  logic [31:0] corner_bits[16] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFC0_0001, 32'h3F80_0000, 32'h3F7F_FFFF,
    32'h0000_0001, 32'h007F_FFFF, 32'h3B4D_2E1C, 32'h3B4D_2E1D,
    32'h3200_0000, 32'h31FF_FFFF, 32'h7F7F_FFFF, 32'h3F00_0000
  };

  linear_to_srgb8_pixel_encoder dut (.*);

  linear_to_srgb8_pixel_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off after 300 transactions
  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = (taken == 300) ? 200 : $urandom_range(0, 9);
      if (taken > 600 && taken < 700) wait_cycles = 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic write_mode(input logic raw);
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
                            input logic [31:0] b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    red_bits   <= r;
    green_bits <= g;
    blue_bits  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] rand_channel();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      v[31]    = ($urandom_range(0, 15) == 0);
      v[30:23] = 8'($urandom_range(98, 127));
    end
    return v;
  endfunction

  task automatic run_phase(input int count, input logic corners);
    int gap;
    if (corners)
      for (int i = 0; i < 16; i++)
        send_pixel(corner_bits[i], corner_bits[(i + 5) % 16], corner_bits[(i + 11) % 16],
                   $urandom_range(0, 9));
    for (int i = 0; i < count; i++) begin
      gap = (i % 100 < 20) ? 0 : $urandom_range(0, 9);
      send_pixel(rand_channel(), rand_channel(), rand_channel(), gap);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_phase(400, 1'b1);
    write_mode(1'b1);
    run_phase(300, 1'b1);
    write_mode(1'b0);
    run_phase(250, 1'b0);
    write_mode(1'b1);
    run_phase(200, 1'b0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
